[hdl/sopb_pkg.sv]
`timescale 1ns / 1ps

package sopb_pkg;

  localparam int CoordW   = 24;
  localparam int RadW     = 16;
  localparam int InDataW  = 272;
  localparam int OutDataW = 40;
  localparam int PushW    = 17;
  localparam int MagW     = 17;
  localparam int SqSteps  = 18;
  localparam int DivSteps = 17;
  localparam logic [15:0] PushMax = 16'hFFFF;

  // Control and operand bits that ride along the root and divider stages
  typedef struct packed {
    logic            vld;
    logic            touch;
    logic            push_ok;
    logic            neg_x;
    logic            neg_z;
    logic [MagW-1:0] mag_x;
    logic [MagW-1:0] mag_z;
    logic [MagW-1:0] rsum;
  } ctl_t;

  typedef struct packed {
    ctl_t        c;
    logic [35:0] qs;
    logic [20:0] rem;
    logic [17:0] root;
  } sq_t;

  typedef struct packed {
    ctl_t        c;
    logic [17:0] den;
    logic [16:0] nx_lo;
    logic [16:0] nz_lo;
    logic [17:0] rx;
    logic [17:0] rz;
    logic [16:0] qx;
    logic [16:0] qz;
  } dv_t;

  // One digit of the square root: two radicand bits in, one root bit out
  function automatic sq_t sq_step(input sq_t s);
    sq_t         o;
    logic [20:0] rem_sh;
    logic [20:0] trial;
    o      = s;
    rem_sh = {s.rem[18:0], s.qs[35:34]};
    trial  = {1'b0, s.root, 2'b01};
    o.qs   = {s.qs[33:0], 2'b00};
    if (rem_sh >= trial) begin
      o.rem  = rem_sh - trial;
      o.root = {s.root[16:0], 1'b1};
    end else begin
      o.rem  = rem_sh;
      o.root = {s.root[16:0], 1'b0};
    end
    return o;
  endfunction

  // One quotient bit for each axis
  function automatic dv_t dv_step(input dv_t s);
    dv_t         o;
    logic [18:0] tx;
    logic [18:0] tz;
    o       = s;
    tx      = {s.rx, s.nx_lo[16]};
    tz      = {s.rz, s.nz_lo[16]};
    o.nx_lo = {s.nx_lo[15:0], 1'b0};
    o.nz_lo = {s.nz_lo[15:0], 1'b0};
    if (tx >= {1'b0, s.den}) begin
      o.rx = 18'(tx - {1'b0, s.den});
      o.qx = {s.qx[15:0], 1'b1};
    end else begin
      o.rx = tx[17:0];
      o.qx = {s.qx[15:0], 1'b0};
    end
    if (tz >= {1'b0, s.den}) begin
      o.rz = 18'(tz - {1'b0, s.den});
      o.qz = {s.qz[15:0], 1'b1};
    end else begin
      o.rz = tz[17:0];
      o.qz = {s.qz[15:0], 1'b0};
    end
    return o;
  endfunction

  // Saturate, apply sign, zero when there is no push
  function automatic logic [PushW-1:0] push_fmt(input logic ok, input logic neg,
                                                input logic [16:0] q);
    logic [15:0]      mag;
    logic [PushW-1:0] val;
    mag = q[16] ? PushMax : q[15:0];
    val = neg ? 17'(-{1'b0, mag}) : {1'b0, mag};
    return ok ? val : '0;
  endfunction

endpackage

[hdl/sphere_overlap_push_back_unit.sv]
`timescale 1ns / 1ps
// Channel  Direction  Payload
// in_      slave      two sphere centers, radii and horizontal velocities
// out_     master     touching flag and horizontal push-back of A
//
// One item per cycle when out_tready stays high.
// The pipe runs through the 18-stage square root and then the 17-stage divider.
// rst_n clears every valid bit; payload registers are not reset.
// A stall on out_tready freezes the whole pipe and drops in_tready.

module sphere_overlap_push_back_unit
  import sopb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, a_vel_x, a_vel_z, b_vel_x, b_vel_z, a_radius, b_radius
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // touching, push_x, push_z, zero pad
  output logic [OutDataW-1:0] out_tdata
);

  logic en;

  // stage 1: differences
  logic               v1_r;
  logic signed [24:0] ex_r, ey_r, ez_r;
  logic signed [25:0] dx_r, dz_r;
  logic [MagW-1:0]    rsum1_r;

  // stage 2: squares
  logic               v2_r;
  logic [48:0]        sx_r, sy_r, sz_r;
  logic [50:0]        hx_r, hz_r;
  logic [33:0]        rsq_r;
  logic               neg_x2_r, neg_z2_r;
  logic [MagW-1:0]    mag_x2_r, mag_z2_r, rsum2_r;

  sq_t sq_r   [0:SqSteps];
  sq_t sq_nxt [0:SqSteps-1];
  dv_t dv_r   [0:DivSteps];
  dv_t dv_nxt [0:DivSteps-1];
  dv_t dv0_nxt;
  sq_t sq0_nxt;

  logic                out_tvalid_r;
  logic [OutDataW-1:0] out_tdata_r;
  logic [OutDataW-1:0] out_tdata_nxt;

  assign en         = !out_tvalid_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r    <= 25'(signed'(in_tdata[23:0]))   - 25'(signed'(in_tdata[95:72]));
      ey_r    <= 25'(signed'(in_tdata[47:24]))  - 25'(signed'(in_tdata[119:96]));
      ez_r    <= 25'(signed'(in_tdata[71:48]))  - 25'(signed'(in_tdata[143:120]));
      dx_r    <= (26'(signed'(in_tdata[23:0])) + 26'(signed'(in_tdata[167:144])))
               - (26'(signed'(in_tdata[95:72])) + 26'(signed'(in_tdata[215:192])));
      dz_r    <= (26'(signed'(in_tdata[71:48])) + 26'(signed'(in_tdata[191:168])))
               - (26'(signed'(in_tdata[143:120])) + 26'(signed'(in_tdata[239:216])));
      rsum1_r <= {1'b0, in_tdata[255:240]} + {1'b0, in_tdata[271:256]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r     <= 49'(ex_r * ex_r);
      sy_r     <= 49'(ey_r * ey_r);
      sz_r     <= 49'(ez_r * ez_r);
      hx_r     <= 51'(dx_r * dx_r);
      hz_r     <= 51'(dz_r * dz_r);
      rsq_r    <= 34'(rsum1_r * rsum1_r);
      neg_x2_r <= dx_r[25];
      neg_z2_r <= dz_r[25];
      mag_x2_r <= dx_r[25] ? 17'(-dx_r) : dx_r[16:0];
      mag_z2_r <= dz_r[25] ? 17'(-dz_r) : dz_r[16:0];
      rsum2_r  <= rsum1_r;
    end
  end

  // stage 3: compare and load the root unit
  always_comb begin
    logic [50:0] dsq3;
    logic [51:0] q;
    dsq3              = {2'b00, sx_r} + {2'b00, sy_r} + {2'b00, sz_r};
    q                 = {1'b0, hx_r} + {1'b0, hz_r};
    sq0_nxt.c.vld     = v2_r;
    sq0_nxt.c.touch   = dsq3 <= {17'd0, rsq_r};
    sq0_nxt.c.push_ok = (q != '0) && ({18'd0, rsq_r} > q);
    sq0_nxt.c.neg_x   = neg_x2_r;
    sq0_nxt.c.neg_z   = neg_z2_r;
    sq0_nxt.c.mag_x   = mag_x2_r;
    sq0_nxt.c.mag_z   = mag_z2_r;
    sq0_nxt.c.rsum    = rsum2_r;
    sq0_nxt.qs        = q[35:0];
    sq0_nxt.rem       = '0;
    sq0_nxt.root      = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r[0].c.vld <= 1'b0;
    end else if (en) begin
      sq_r[0] <= sq0_nxt;
    end
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sq
    assign sq_nxt[k] = sq_step(sq_r[k]);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[k+1].c.vld <= 1'b0;
      end else if (en) begin
        sq_r[k+1] <= sq_nxt[k];
      end
    end
  end

  // overlap times offset, plus d for rounding; quotient fits in 17 bits
  always_comb begin
    logic [16:0] d;
    logic [16:0] ov;
    logic [34:0] nx;
    logic [34:0] nz;
    d           = sq_r[SqSteps].root[16:0];
    ov          = sq_r[SqSteps].c.rsum - d;
    nx          = 35'(sq_r[SqSteps].c.mag_x * ov) + {18'd0, d};
    nz          = 35'(sq_r[SqSteps].c.mag_z * ov) + {18'd0, d};
    dv0_nxt.c   = sq_r[SqSteps].c;
    dv0_nxt.den = {d, 1'b0};
    dv0_nxt.rx  = nx[34:17];
    dv0_nxt.rz  = nz[34:17];
    dv0_nxt.nx_lo = nx[16:0];
    dv0_nxt.nz_lo = nz[16:0];
    dv0_nxt.qx  = '0;
    dv0_nxt.qz  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0].c.vld <= 1'b0;
    end else if (en) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_dv
    assign dv_nxt[k] = dv_step(dv_r[k]);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1].c.vld <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_nxt[k];
      end
    end
  end

  assign out_tdata_nxt = {5'd0,
                          push_fmt(dv_r[DivSteps].c.push_ok, dv_r[DivSteps].c.neg_z,
                                   dv_r[DivSteps].qz),
                          push_fmt(dv_r[DivSteps].c.push_ok, dv_r[DivSteps].c.neg_x,
                                   dv_r[DivSteps].qx),
                          dv_r[DivSteps].c.touch};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= dv_r[DivSteps].c.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

endmodule

[hdl/sopb_checker.sv]
`timescale 1ns / 1ps

module sopb_checker
  import sopb_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out item changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("in item taken while pipe is frozen");

  a_push_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17:1] != 17'h10000) && (out_tdata[34:18] != 17'h10000)
                   && (out_tdata[39:35] == 5'd0))
    else $error("push out of range or pad set");

endmodule

bind sphere_overlap_push_back_unit sopb_checker u_sopb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
